// ----- hdl/fctp_pkg.sv -----
// Shared types, codes and constants of the function call time profiler.
`timescale 1ns / 1ps
package fctp_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] HASH_MUL    = 32'd31;
    localparam logic [9:0]  CREATED_MAX = 10'd1023;
    localparam logic [1:0]  OPC_ENTER   = 2'd0;
    localparam logic [1:0]  OPC_EXIT    = 2'd1;
    localparam logic        REG_ENABLE  = 1'b0;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DISABLED  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] address;
        logic [63:0] timestamp;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] completed_calls;
        logic [63:0] total_time;
        logic [63:0] min_time;
        logic [63:0] max_time;
        logic [63:0] elapsed_time;
        logic [15:0] nesting_depth;
        logic [9:0]  functions_tracked;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [63:0] address;
        logic [63:0] timestamp;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [63:0] address;
        logic [15:0] depth;
        logic [63:0] start;
        logic [31:0] count;
        logic [63:0] total;
        logic [63:0] min_time;
        logic [63:0] max_time;
    } t_entry;

endpackage

// ----- hdl/fctp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fctp_ram #(
    parameter int WIDTH = $bits(fctp_pkg::t_entry),
    parameter int DEPTH = fctp_pkg::BUCKETS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- hdl/fctp_fifo.sv -----
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module fctp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fctp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ----- hdl/fctp_front.sv -----
// Front end: takes events, classifies the opcode and hashes the address to a bucket.
`timescale 1ns / 1ps
module fctp_front #(
    parameter int BUCKETS = fctp_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  fctp_pkg::t_in_item         i_item,
    output logic                       o_full,
    output logic                       o_cmd_push,
    input  logic                       i_cmd_full,
    output fctp_pkg::t_cmd             o_cmd,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);
    import fctp_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam bit POW2 = (BUCKETS == (1 << BW));
    localparam logic [31:0] BKT_N = 32'(BUCKETS);
    // Rounded-up reciprocal: the quotient of any 32-bit hash is exact after the shift.
    localparam logic [64:0] RECIP_FULL =
        ((65'd1 << (32 + BW)) + 65'(BUCKETS) - 65'd1) / 65'(BUCKETS);
    localparam logic [32:0] RECIP = RECIP_FULL[32:0];

    logic          r_vld;
    logic          r_done;
    logic          r_phase;
    t_cmd          r_cmd;
    logic [31:0]   r_h;
    logic [64:0]   r_prod;
    logic [BW-1:0] r_rem;
    logic          accept;
    logic [31:0]   folded;
    logic [31:0]   n_h;
    logic [64:0]   n_prod;
    logic [64:0]   quot;
    logic [31:0]   qb;
    logic [31:0]   diff;
    logic [BW-1:0] n_rem;
    t_op           op;

    assign accept = i_push && !r_vld;
    assign o_full = r_vld;
    assign folded = i_item.address[31:0] ^ i_item.address[63:32];
    assign n_h    = folded * HASH_MUL;

    always_comb begin
        unique case (i_item.opcode)
            OPC_ENTER: op = OP_ENTER;
            OPC_EXIT:  op = OP_EXIT;
            default:   op = OP_QUERY;
        endcase
    end

    // Remainder by reciprocal multiplication: the product is registered, then the subtraction follows in the next.
    assign n_prod = {33'b0, r_h} * {32'b0, RECIP};
    assign quot   = r_prod >> (32 + BW);
    assign qb     = quot[31:0] * BKT_N;
    assign diff   = r_h - qb;
    assign n_rem  = diff[BW-1:0];

    assign o_cmd_push = r_vld && r_done && !i_cmd_full;
    assign o_cmd      = r_cmd;
    assign o_bucket   = POW2 ? r_h[BW-1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else if (accept) begin
            r_vld   <= 1'b1;
            r_done  <= POW2;
            r_phase <= 1'b0;
        end else if (r_vld && !r_done) begin
            r_phase <= 1'b1;
            if (r_phase) begin
                r_done <= 1'b1;
            end
        end else if (o_cmd_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= '{op: op, address: i_item.address, timestamp: i_item.timestamp};
            r_h   <= n_h;
        end else if (r_vld && !r_done) begin
            if (!r_phase) begin
                r_prod <= n_prod;
            end else begin
                r_rem <= n_rem;
            end
        end
    end
endmodule

// ----- hdl/fctp_back.sv -----
// Back end: reads a bucket, picks the way, updates the entry and builds the result.
`timescale 1ns / 1ps
module fctp_back #(
    parameter int BUCKETS = fctp_pkg::BUCKETS_DEF,
    parameter int WAYS    = fctp_pkg::WAYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_enable,
    input  logic                       i_cmd_empty,
    output logic                       o_cmd_pop,
    input  fctp_pkg::t_cmd             i_cmd,
    input  logic [$clog2(BUCKETS)-1:0] i_bucket,
    input  logic                       i_res_full,
    output logic                       o_res_push,
    output fctp_pkg::t_out_item        o_res
);
    import fctp_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW = $bits(t_entry);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_CALC  = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [BW-1:0] r_clr;
    logic [BW-1:0] r_row;
    t_cmd          r_cmd;
    t_status       r_status;
    logic [WW-1:0] r_way;
    t_entry        r_ent;
    logic          r_create;
    logic [63:0]   r_el;
    logic [9:0]    r_created;

    logic [EW-1:0] rd_raw [WAYS];
    t_entry        rd     [WAYS];
    logic [WAYS-1:0] ram_we;
    logic [BW-1:0] ram_waddr;
    t_entry        ram_wdata;

    logic          found;
    logic          has_free;
    logic [WW-1:0] hway;
    logic [WW-1:0] fway;
    t_status       n_status;
    logic [WW-1:0] n_way;
    logic          n_create;
    t_entry        n_ent;
    t_entry        upd;
    logic [64:0]   sum;
    logic          exit_ok;

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        fctp_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_waddr),
            .i_wdata (ram_wdata),
            .i_re    (o_cmd_pop),
            .i_raddr (i_bucket),
            .o_rdata (rd_raw[g])
        );
        assign rd[g] = rd_raw[g];
    end

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty && !i_res_full;

    // Way search: the lowest matching way, else the lowest empty way.
    always_comb begin
        found    = 1'b0;
        has_free = 1'b0;
        hway     = '0;
        fway     = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd[w].valid && rd[w].address == r_cmd.address) begin
                found = 1'b1;
                hway  = WW'(w);
            end
            if (!rd[w].valid) begin
                has_free = 1'b1;
                fway     = WW'(w);
            end
        end
    end

    always_comb begin
        n_create = 1'b0;
        n_way    = hway;
        if (r_cmd.op != OP_QUERY && !i_enable) begin
            n_status = ST_DISABLED;
        end else if (r_cmd.op == OP_ENTER) begin
            if (found) begin
                n_status = ST_OK;
            end else if (has_free) begin
                n_status = ST_OK;
                n_create = 1'b1;
                n_way    = fway;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            n_status = found ? ST_OK : ST_NOT_FOUND;
        end
        if (n_create) begin
            n_ent = '{valid: 1'b1, address: r_cmd.address, depth: '0, start: '0,
                      count: '0, total: '0, min_time: '1, max_time: '0};
        end else begin
            n_ent = rd[hway];
        end
    end

    assign exit_ok = (r_cmd.op == OP_EXIT) && (r_status == ST_OK);
    assign sum     = {1'b0, r_ent.total} + {1'b0, r_el};

    always_comb begin
        upd = r_ent;
        if (exit_ok) begin
            if (r_ent.count != '1) begin
                upd.count = r_ent.count + 1'b1;
            end
            upd.total = sum[64] ? '1 : sum[63:0];
            if (r_el < r_ent.min_time) begin
                upd.min_time = r_el;
            end
            if (r_el > r_ent.max_time) begin
                upd.max_time = r_el;
            end
        end
    end

    always_comb begin
        ram_we    = '0;
        ram_waddr = r_row;
        ram_wdata = upd;
        if (r_state == S_CLEAR) begin
            ram_we    = '1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_UPD && r_status == ST_OK && r_cmd.op != OP_QUERY) begin
            ram_we[r_way] = 1'b1;
        end
    end

    assign o_res_push = (r_state == S_UPD);

    always_comb begin
        o_res                   = '0;
        o_res.status            = r_status;
        o_res.functions_tracked = r_created;
        if (r_status == ST_OK) begin
            o_res.completed_calls = upd.count;
            o_res.total_time      = upd.total;
            o_res.min_time        = upd.min_time;
            o_res.max_time        = upd.max_time;
            o_res.elapsed_time    = r_el;
            o_res.nesting_depth   = upd.depth;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_CALC;
            S_CALC:  n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_created <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_CALC && r_create && r_created != CREATED_MAX) begin
                r_created <= r_created + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_row <= i_bucket;
        end
        if (r_state == S_RD) begin
            r_status <= n_status;
            r_way    <= n_way;
            r_ent    <= n_ent;
            r_create <= n_create && (n_status == ST_OK);
        end
        if (r_state == S_CALC) begin
            r_el <= exit_ok ? (r_cmd.timestamp - r_ent.start) : '0;
            if (r_status == ST_OK && r_cmd.op == OP_ENTER) begin
                if (r_ent.depth != '1) begin
                    r_ent.depth <= r_ent.depth + 1'b1;
                end
                r_ent.start <= r_cmd.timestamp;
            end else if (exit_ok) begin
                if (r_ent.depth != '0) begin
                    r_ent.depth <= r_ent.depth - 1'b1;
                end
            end
        end
    end

    a_res_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_pop_reads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_RD))
        else $error("popped command not followed by a bucket read");

    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.status != ST_OK) |->
            (o_res.completed_calls == '0 && o_res.nesting_depth == '0 &&
             o_res.elapsed_time == '0))
        else $error("failed event reports entry fields");

    a_created_mono : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_created >= $past(r_created)))
        else $error("created count went down");
endmodule

// ----- hdl/function_call_time_profiler.sv -----
// Top level of the function call time profiler: queues, front, back and register port.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake               Payload
//  events    in         push / full             i_item   (fctp_pkg::t_in_item)
//  results   out        pop / empty             o_result (fctp_pkg::t_out_item)
//  config    in         APB psel/penable/pready enable register at byte address 0
//
//  The back end takes each event through a bucket read, the way search, the depth and
//  elapsed-time step, and the statistics update with the write back. Because of that
//  read-modify-write of one table row, no new event starts before the last is written
//  back. The front end holds an event until the command queue takes it; when BUCKETS
//  is not a power of two it first runs a reciprocal multiplication, then the remainder
//  subtraction. This work overlaps with the back end.
//  After reset a clearing pass writes every bucket row empty; events offered meanwhile
//  wait in the front and the command queue, so full stays high once three are held.
//  Register writes are taken at all times.
//  A full result queue stalls the back end; the front keeps filling the command queue.
//
module function_call_time_profiler #(
    parameter int BUCKETS = fctp_pkg::BUCKETS_DEF,
    parameter int WAYS    = fctp_pkg::WAYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Event side.
    input  logic                push,
    output logic                full,
    input  fctp_pkg::t_in_item  i_item,
    // Result side.
    input  logic                pop,
    output logic                empty,
    output fctp_pkg::t_out_item o_result,
    // Register port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fctp_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int QW = $bits(t_cmd) + BW;

    logic          r_enable;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    t_cmd          front_cmd;
    logic [BW-1:0] front_bucket;
    t_cmd          back_cmd;
    logic [BW-1:0] back_bucket;
    logic          res_push;
    logic          res_full;
    t_out_item     res;

    // The register port never waits; a write completes in its access cycle.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, r_enable} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    // The front accepts and hashes events while the back is still busy.
    fctp_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (front_cmd),
        .o_bucket   (front_bucket)
    );

    // Command queue carries each classified event together with its bucket number.
    fctp_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({front_cmd, front_bucket}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  ({back_cmd, back_bucket}),
        .o_empty (cmd_empty)
    );

    // The back only starts an event when the result queue has room for its transfer.
    fctp_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (back_cmd),
        .i_bucket    (back_bucket),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue doubles as the output register seen by the consumer.
    fctp_fifo #(.WIDTH($bits(t_out_item)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );
endmodule

// ----- bench/function_call_time_profiler_test.sv -----
// Testbench of the function call time profiler: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

// The profile table model: predicts the result of every accepted event and checks
// each result transfer against the oldest prediction.
class profile_scoreboard;
    localparam int NBUCKETS = fctp_pkg::BUCKETS_DEF;
    localparam int NWAYS    = fctp_pkg::WAYS_DEF;
    localparam int NSLOTS   = NBUCKETS * NWAYS;

    bit          slot_valid [NSLOTS];
    logic [63:0] slot_addr  [NSLOTS];
    logic [15:0] slot_depth [NSLOTS];
    logic [63:0] slot_start [NSLOTS];
    logic [31:0] slot_count [NSLOTS];
    logic [63:0] slot_total [NSLOTS];
    logic [63:0] slot_min   [NSLOTS];
    logic [63:0] slot_max   [NSLOTS];
    logic [9:0]  created;
    bit          enabled;
    fctp_pkg::t_out_item pending_results[$];
    int          mismatches;

    function new();
        int i;
        for (i = 0; i < NSLOTS; i++) slot_valid[i] = 1'b0;
        created = '0;
        enabled = 1'b0;
        mismatches = 0;
    endfunction

    function int bucket_base(logic [63:0] a);
        logic [31:0] h;
        h = a[31:0] ^ a[63:32];
        h = h * 32'd31;
        return int'(h % NBUCKETS) * NWAYS;
    endfunction

    function fctp_pkg::t_out_item report(fctp_pkg::t_status st, int s, logic [63:0] el);
        fctp_pkg::t_out_item r;
        r = '0;
        r.status = st;
        if (s >= 0) begin
            r.completed_calls = slot_count[s];
            r.total_time      = slot_total[s];
            r.min_time        = slot_min[s];
            r.max_time        = slot_max[s];
            r.elapsed_time    = el;
            r.nesting_depth   = slot_depth[s];
        end
        r.functions_tracked = created;
        return r;
    endfunction

    // Notes an accepted event: updates the table and queues the predicted result.
    function void note_event(fctp_pkg::t_in_item it);
        int base;
        int s;
        int w;
        logic [63:0] el;
        fctp_pkg::t_out_item r;
        base = bucket_base(it.address);
        s = -1;
        for (w = 0; w < NWAYS; w++)
            if (s < 0 && slot_valid[base + w] && slot_addr[base + w] == it.address)
                s = base + w;
        if ((it.opcode == fctp_pkg::OP_ENTER || it.opcode == fctp_pkg::OP_EXIT) && !enabled)
            r = report(fctp_pkg::ST_DISABLED, -1, '0);
        else if (it.opcode == fctp_pkg::OP_ENTER) begin
            if (s < 0) begin
                for (w = 0; w < NWAYS; w++)
                    if (s < 0 && !slot_valid[base + w]) s = base + w;
                if (s >= 0) begin
                    slot_valid[s] = 1'b1;
                    slot_addr[s]  = it.address;
                    slot_depth[s] = '0;
                    slot_count[s] = '0;
                    slot_total[s] = '0;
                    slot_min[s]   = '1;
                    slot_max[s]   = '0;
                    if (created != fctp_pkg::CREATED_MAX) created++;
                end
            end
            if (s < 0)
                r = report(fctp_pkg::ST_FULL, -1, '0);
            else begin
                if (slot_depth[s] != 16'hFFFF) slot_depth[s]++;
                slot_start[s] = it.timestamp;
                r = report(fctp_pkg::ST_OK, s, '0);
            end
        end else if (it.opcode == fctp_pkg::OP_EXIT) begin
            if (s < 0)
                r = report(fctp_pkg::ST_NOT_FOUND, -1, '0);
            else begin
                if (slot_depth[s] != 0) slot_depth[s]--;
                el = it.timestamp - slot_start[s];
                if (slot_count[s] != 32'hFFFF_FFFF) slot_count[s]++;
                if (slot_total[s] > ~el) slot_total[s] = '1;
                else slot_total[s] += el;
                if (el < slot_min[s]) slot_min[s] = el;
                if (el > slot_max[s]) slot_max[s] = el;
                r = report(fctp_pkg::ST_OK, s, el);
            end
        end else begin
            // Queries, and the unused fourth opcode, only read the entry.
            r = report(s < 0 ? fctp_pkg::ST_NOT_FOUND : fctp_pkg::ST_OK, s, '0);
        end
        pending_results.push_back(r);
    endfunction

    // Checks one result transfer against the oldest prediction.
    function void check_result(fctp_pkg::t_out_item got);
        fctp_pkg::t_out_item exp;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.completed_calls !== exp.completed_calls
            || got.total_time !== exp.total_time || got.min_time !== exp.min_time
            || got.max_time !== exp.max_time || got.elapsed_time !== exp.elapsed_time
            || got.nesting_depth !== exp.nesting_depth
            || got.functions_tracked !== exp.functions_tracked) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %h actual %h", exp, got);
        end
    endfunction
endclass

module function_call_time_profiler_test;
    import fctp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        pop;
    logic        empty;
    t_out_item   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    profile_scoreboard table_model;
    int  cycles;
    bit  steady_pop;    // When set, the result side never stalls.
    bit  steady_push;   // When set, the event side never idles.
    logic [63:0] addr_pool[16];
    logic [63:0] clock_ns;

    function_call_time_profiler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .pop     (pop),
        .empty   (empty),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog over the whole run, the clearing pass after reset included.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: every accepted result transfer is checked at the rising edge;
    // pop is changed at the falling edge, stalling at random unless steady.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) table_model.check_result(o_result);
    end
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= steady_pop || ($urandom_range(99) >= 27);
    end

    // Offers one event and waits for its transfer; idles first at random. push is left
    // high on return, so the next event or drain decides its value at that falling edge.
    task automatic send_event(input t_in_item it);
        if (!steady_push) begin
            while ($urandom_range(99) < 27) begin
                push <= 1'b0;
                @(negedge i_clk);
            end
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        table_model.note_event(it);
        @(negedge i_clk);
    endtask

    task automatic send_op(input t_op op, input logic [63:0] a, input logic [63:0] t);
        t_in_item it;
        it.opcode = op;
        it.address = a;
        it.timestamp = t;
        send_event(it);
    endtask

    // Stops offering events, then waits until every predicted result has arrived,
    // plus a latency margin.
    task automatic drain();
        push <= 1'b0;
        while (table_model.pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Register write through the APB port after a drain: setup then access.
    task automatic write_enable(input bit value);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'd0; pwdata <= {31'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        table_model.enabled = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Random event, mostly enter and exit on a small pool of addresses.
    task automatic random_event();
        logic [63:0] a;
        int k;
        k = $urandom_range(99);
        if (k < 80) a = addr_pool[$urandom_range(15)];
        else a = {$urandom, $urandom};
        clock_ns = clock_ns + $urandom_range(5000);
        k = $urandom_range(99);
        if (k < 45) send_op(OP_ENTER, a, clock_ns);
        else if (k < 85) send_op(OP_EXIT, a, clock_ns);
        else if (k < 95) send_op(OP_QUERY, a, {$urandom, $urandom});
        else begin
            // Fourth opcode, sent as a raw item so its bit pattern is covered.
            t_in_item it;
            it.opcode = 2'd3;
            it.address = a;
            it.timestamp = {$urandom, $urandom};
            send_event(it);
        end
    endtask

    initial begin
        int i;
        table_model = new();
        cycles = 0;
        steady_pop = 1'b0;
        steady_push = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0; i_item = '0;
        pop = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        clock_ns = 64'd100;
        for (i = 0; i < 16; i++) addr_pool[i] = {$urandom, $urandom};
        // Three addresses of one bucket so the bucket full case comes up.
        addr_pool[0] = 64'h0000_0001_0000_0001;
        addr_pool[1] = 64'h0000_0002_0000_0002;
        addr_pool[2] = 64'h0000_0003_0000_0003;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: disabled events, queries, extremes, wrap, bucket full.
        send_op(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
        send_op(OP_EXIT, 64'd0, 64'd5);
        send_op(OP_QUERY, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_enable(1'b1);
        send_op(OP_EXIT, 64'd0, 64'd0);
        send_op(OP_ENTER, 64'd0, 64'd0);
        send_op(OP_ENTER, 64'd0, 64'd10);
        send_op(OP_EXIT, 64'd0, 64'd25);
        send_op(OP_EXIT, 64'd0, 64'd30);
        send_op(OP_EXIT, 64'd0, 64'd31);
        send_op(OP_QUERY, 64'd0, 64'd0);
        send_op(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        send_op(OP_EXIT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h10);
        send_op(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_op(OP_EXIT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(OP_ENTER, addr_pool[0], 64'd1);
        send_op(OP_ENTER, addr_pool[1], 64'd2);
        send_op(OP_ENTER, addr_pool[2], 64'd3);
        send_op(OP_EXIT, addr_pool[2], 64'd4);
        send_op(OP_QUERY, addr_pool[1], 64'd0);

        // Random part with phases of the enable setting and a steady stretch.
        for (i = 0; i < 1150; i++) begin
            if (i == 200) write_enable(1'b0);
            if (i == 260) write_enable(1'b1);
            if (i == 500) begin
                // Sender holds off until every result has come.
                drain();
                steady_push = 1'b1;
                steady_pop = 1'b1;
            end
            if (i == 700) begin
                steady_push = 1'b0;
                steady_pop = 1'b0;
            end
            random_event();
        end

        drain();
        if (table_model.mismatches == 0 && table_model.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- function_call_time_profiler.f -----
hdl/fctp_pkg.sv
hdl/fctp_ram.sv
hdl/fctp_fifo.sv
hdl/fctp_front.sv
hdl/fctp_back.sv
hdl/function_call_time_profiler.sv
bench/function_call_time_profiler_test.sv
